FILE: src/nmb_pkg.sv
package nmb_pkg;

  // Fraction bits of the unit component, one pipeline stage per bit
  localparam int FracBits = 16;
  // Sum of squares of three components in [-765, 765]
  localparam int SumBits = 21;
  // Square of one component magnitude
  localparam int SqBits = 20;
  // Remainder of the root search: square shifted up by two fraction widths
  localparam int RemBits = SqBits + 2 * FracBits;
  // Running product magnitude * sum
  localparam int ProdBits = SumBits + FracBits;
  // Bit index width for the search stages
  localparam int PosBits = $clog2(FracBits);

  typedef struct packed {
    logic [7:0] base_x;
    logic [7:0] base_y;
    logic [7:0] base_z;
    logic [7:0] detail_x;
    logic [7:0] detail_y;
    logic [7:0] detail_z;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic [7:0] out_z;
  } res_t;

  // State carried through the root search stages
  typedef struct packed {
    logic [2:0]                     neg;
    logic [SumBits-1:0]             sum;
    logic [2:0][RemBits-1:0]        rem;
    logic [2:0][ProdBits-1:0]       prod;
    logic [2:0][FracBits-1:0]       mag;
  } iter_t;

endpackage

FILE: src/nmb_root_step.sv
module nmb_root_step
  import nmb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [PosBits-1:0] bit_pos,
  input  logic               adv,
  input  logic               in_valid,
  input  iter_t              in_state,
  output logic               valid,
  output iter_t              state
);

  localparam int DiffBits = RemBits + 2;

  iter_t state_next;

  // Try one magnitude bit for each component: keep it if the trial square fits
  always_comb begin
    logic [DiffBits-1:0] trial;
    logic [DiffBits-1:0] rem_ext;
    state_next = in_state;
    for (int i = 0; i < 3; i++) begin
      trial = ({{(DiffBits-ProdBits){1'b0}}, in_state.prod[i]} << ({1'b0, bit_pos} + 5'd1))
            + ({{(DiffBits-SumBits){1'b0}}, in_state.sum} << {bit_pos, 1'b0});
      rem_ext = {2'b00, in_state.rem[i]};
      if (rem_ext >= trial) begin
        state_next.rem[i]  = in_state.rem[i] - trial[RemBits-1:0];
        state_next.prod[i] = in_state.prod[i]
                           + ({{(ProdBits-SumBits){1'b0}}, in_state.sum} << bit_pos);
        state_next.mag[i]  = in_state.mag[i] | (FracBits'(1) << bit_pos);
      end
    end
  end

  // Advance the stage when the downstream side can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state <= state_next;
    end
  end

endmodule

FILE: src/normal_map_blend.sv
// Blend of one base and one detail normal-map pixel, renormalised to unit length.
// Pipeline: 3 front stages, 16 root search stages of one bit each, 1 output stage.
// Throughput: one pixel per cycle unless res_ready holds the output stage;
// each stage holds independently, so bubbles close up.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
module normal_map_blend
  import nmb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  pix_t pix,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // Front stage registers
  logic              va;
  logic [2:0]        a_neg;
  logic [2:0][9:0]   a_mag;
  logic              vq;
  logic [2:0]        q_neg;
  logic [2:0][SqBits-1:0] q_sq;
  logic              vs;
  iter_t             s_state;

  logic [FracBits-1:0]  vi;
  iter_t                it_state [FracBits];
  logic [FracBits-1:0]  adv_i;

  logic adv_a;
  logic adv_q;
  logic adv_s;
  logic adv_o;

  // Stage advance chain: a stage moves when empty or when its successor moves
  assign adv_o = !res_valid || res_ready;
  assign adv_s = !vs || adv_i[0];
  assign adv_q = !vq || adv_s;
  assign adv_a = !va || adv_q;
  assign pix_ready = adv_a;

  always_comb begin
    adv_i[FracBits-1] = !vi[FracBits-1] || adv_o;
    for (int k = FracBits - 2; k >= 0; k--) begin
      adv_i[k] = !vi[k] || adv_i[k+1];
    end
  end

  // Map byte pairs to odd components 4b + 2d - 765 and split sign and magnitude
  logic [2:0][11:0] a_raw;
  logic [2:0][7:0]  b_in;
  logic [2:0][7:0]  d_in;

  always_comb begin
    b_in = {pix.base_z, pix.base_y, pix.base_x};
    d_in = {pix.detail_z, pix.detail_y, pix.detail_x};
    for (int i = 0; i < 3; i++) begin
      a_raw[i] = {2'b00, b_in[i], 2'b00} + {3'b000, d_in[i], 1'b0} - 12'd765;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv_a) begin
      va <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= a_raw[i][11];
        a_mag[i] <= a_raw[i][11] ? 10'(-a_raw[i]) : a_raw[i][9:0];
      end
    end
  end

  // Square each magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (adv_q) begin
      vq <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_q) begin
      q_neg <= a_neg;
      for (int i = 0; i < 3; i++) begin
        q_sq[i] <= a_mag[i] * a_mag[i];
      end
    end
  end

  // Sum the squares and seed the root search
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv_s) begin
      vs <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s) begin
      s_state.neg <= q_neg;
      s_state.sum <= {1'b0, q_sq[0]} + {1'b0, q_sq[1]} + {1'b0, q_sq[2]};
      for (int i = 0; i < 3; i++) begin
        s_state.rem[i]  <= {q_sq[i], {(2 * FracBits){1'b0}}};
        s_state.prod[i] <= '0;
        s_state.mag[i]  <= '0;
      end
    end
  end

  // Root search, most significant magnitude bit first
  for (genvar k = 0; k < FracBits; k++) begin : g_step
    nmb_root_step u_step (
      .clk      (clk),
      .rst      (rst),
      .bit_pos  (PosBits'(FracBits - 1 - k)),
      .adv      (adv_i[k]),
      .in_valid ((k == 0) ? vs : vi[(k == 0) ? 0 : k - 1]),
      .in_state ((k == 0) ? s_state : it_state[(k == 0) ? 0 : k - 1]),
      .valid    (vi[k]),
      .state    (it_state[k])
    );
  end

  // Map each signed unit component back to a byte: floor((1 + c) * 255 / 2)
  iter_t fin;
  res_t  res_next;

  always_comb begin
    logic [2:0][FracBits:0]   v;
    logic [2:0][FracBits+8:0] w;
    fin = it_state[FracBits-1];
    for (int i = 0; i < 3; i++) begin
      v[i] = fin.neg[i] ? ((FracBits+1)'(1) << FracBits) - {1'b0, fin.mag[i]}
                        : ((FracBits+1)'(1) << FracBits) + {1'b0, fin.mag[i]};
      w[i] = {v[i], 8'b0} - {8'b0, v[i]};
    end
    res_next.out_x = w[0][FracBits+8:FracBits+1];
    res_next.out_y = w[1][FracBits+8:FracBits+1];
    res_next.out_z = w[2][FracBits+8:FracBits+1];
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_o) begin
      res_valid <= vi[FracBits-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      res <= res_next;
    end
  end

endmodule
